@@ hw/rtl/bfpf_pkg.sv @@
// ----------------------------------------------------------------------------
// bfpf_pkg
// Shared widths, constants and lane result types of the pulse finder.
// ----------------------------------------------------------------------------
`default_nettype none

package bfpf_pkg;

	localparam int WAVE_W  = 64;
	localparam int LANE_N  = 8;
	localparam int LANE_W  = 8;
	localparam int ENTRY_N = 4;
	localparam int SLOT_N  = 3;
	localparam int POS_W   = 6;
	localparam int WID_W   = 5;
	localparam int LIDX_W  = 3;
	localparam int EXT_W   = LANE_N * LANE_W + 3;

	localparam logic [WID_W-1:0] WIDTH_CAP      = 5'd31;
	localparam logic [WID_W-1:0] END_WIDTH      = 5'd1;
	localparam logic [POS_W-1:0] SPLIT_OFS      = 6'd31;
	localparam logic [POS_W-1:0] LATE_START_POS = 6'd1;
	localparam logic [POS_W:0]   SPLIT_MIN      = 7'd32;

	// Gap-fill tables of one lane, one row per entry state {x, y}
	typedef struct packed {
		logic [ENTRY_N-1:0][1:0]        exit_st;
		logic [ENTRY_N-1:0][LANE_W-1:0] bits;
	} clean_tab_t;

	// First falling edges of one lane
	typedef struct packed {
		logic [1:0]                    cnt;
		logic [SLOT_N-1:0][LIDX_W-1:0] idx;
	} fall_lane_t;

	// Last rising edge of one lane
	typedef struct packed {
		logic              found;
		logic [LIDX_W-1:0] idx;
	} rise_lane_t;

endpackage

`default_nettype wire

@@ hw/rtl/bfpf_clean_lane.sv @@
// ----------------------------------------------------------------------------
// bfpf_clean_lane
// Gap-fill pass over eight bins, evaluated for all four entry states.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpf_clean_lane (
	input  wire logic [bfpf_pkg::LANE_W:0] win,
	output bfpf_pkg::clean_tab_t           tab
);

	always_comb begin
		logic x;
		logic y;
		logic p1;
		logic y1;
		tab = '0;
		for (int e = 0; e < bfpf_pkg::ENTRY_N; e++) begin
			x = 1'(e >> 1);
			y = 1'(e);
			for (int j = 0; j < bfpf_pkg::LANE_W; j++) begin
				// fill 1101, then 1011, on the bits already changed
				p1 = win[j] | (x & y & win[j+1]);
				y1 = y | (x & ~y & p1 & win[j+1]);
				tab.bits[e][j] = y1;
				x = y1;
				y = p1;
			end
			tab.exit_st[e] = {x, y};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bfpf_fall_lane.sv @@
// ----------------------------------------------------------------------------
// bfpf_fall_lane
// Find the first three marked falls among eight bins.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpf_fall_lane (
	input  wire logic [bfpf_pkg::LANE_W-1:0] ev,
	output bfpf_pkg::fall_lane_t             res
);

	always_comb begin
		res = '0;
		for (int j = 0; j < bfpf_pkg::LANE_W; j++) begin
			if (ev[j] && res.cnt != 2'(bfpf_pkg::SLOT_N)) begin
				res.idx[res.cnt] = bfpf_pkg::LIDX_W'(j);
				res.cnt          = res.cnt + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bfpf_rise_lane.sv @@
// ----------------------------------------------------------------------------
// bfpf_rise_lane
// Find the last rising edge among eight bins.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpf_rise_lane (
	input  wire logic [bfpf_pkg::LANE_W-1:0] ev,
	output bfpf_pkg::rise_lane_t             res
);

	always_comb begin
		res = '0;
		for (int j = 0; j < bfpf_pkg::LANE_W; j++) begin
			if (ev[j]) begin
				res.found = 1'b1;
				res.idx   = bfpf_pkg::LIDX_W'(j);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/binary_waveform_pulse_finder_top.sv @@
// Each item passes the stage registers, then the output register offers its result.
// Throughput: one item per cycle; six pipeline stages advance together and
// fill any bubble, so a waiting result only stalls once every stage is full.
// Reset: arst_n clears the stage valid flags only; no memory and no
// clearing pass, so items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// binary_waveform_pulse_finder_top
// Cleans a 64-bin discriminator waveform and reports the start and width of
// up to two pulses. Eight lanes of eight bins work side by side in each
// step; a merging stage after each lane row joins what the lanes found.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_waveform_pulse_finder_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wave_valid,
	output logic                               wave_ready,
	input  wire logic [bfpf_pkg::WAVE_W-1:0]   waveform,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [bfpf_pkg::POS_W-1:0]         first_start,
	output logic [bfpf_pkg::WID_W-1:0]         first_width,
	output logic [bfpf_pkg::POS_W-1:0]         second_start,
	output logic [bfpf_pkg::WID_W-1:0]         second_width
);

	localparam int LW = bfpf_pkg::LANE_W;
	localparam int LN = bfpf_pkg::LANE_N;
	localparam int WW = bfpf_pkg::WAVE_W;
	localparam int PW = bfpf_pkg::POS_W;

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage loads when it is empty or when the
	// stage after it loads in the same cycle.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_vld_q;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_out;

	assign adv_out    = ~out_vld_q | result_ready;
	assign adv_s5     = ~vld_s5 | adv_out;
	assign adv_s4     = ~vld_s4 | adv_s5;
	assign adv_s3     = ~vld_s3 | adv_s4;
	assign adv_s2     = ~vld_s2 | adv_s3;
	assign adv_s1     = ~vld_s1 | adv_s2;
	assign wave_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv_s1)  vld_s1    <= wave_valid;
			if (adv_s2)  vld_s2    <= vld_s1;
			if (adv_s3)  vld_s3    <= vld_s2;
			if (adv_s4)  vld_s4    <= vld_s3;
			if (adv_s5)  vld_s5    <= vld_s4;
			if (adv_out) out_vld_q <= vld_s5;
		end
	end

	assign result_valid = out_vld_q;

	// ------------------------------------------------------------------
	// Stage 1: gap fill. The pass runs left to right and carries the two
	// latest (already changed) bits as state, so each lane tabulates its
	// eight steps for all four entry states. Pad three zero bins on top:
	// with no bin to the right a step only shifts, which flushes bins 62
	// and 63 out of the last lane unchanged.
	// ------------------------------------------------------------------
	logic [bfpf_pkg::EXT_W-1:0] wave_ext;
	bfpf_pkg::clean_tab_t       tab_c  [LN];
	bfpf_pkg::clean_tab_t       tab_s1 [LN];
	logic [1:0]                 head_s1;

	assign wave_ext = {(bfpf_pkg::EXT_W - WW)'(0), waveform};

	for (genvar k = 0; k < LN; k++) begin : g_clean
		bfpf_clean_lane u_clean_lane (
			.win (wave_ext[2 + LW*k +: LW + 1]),
			.tab (tab_c[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tab_s1  <= tab_c;
			head_s1 <= {waveform[0], waveform[1]};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: chain the lane tables from the state {bin 0, bin 1}, then
	// drop isolated ones. Dropping a one never feeds the next step (its
	// right-hand neighbour is already zero), so that pass is one gate per
	// bin; bin 0 needs bin 1, and bin 63 looks at the cleaned bin 62.
	// ------------------------------------------------------------------
	logic [WW:0]   fill_v;
	logic [WW-1:0] clean_c;
	logic [WW-1:0] clean_s2;

	always_comb begin
		logic [1:0] st;
		st        = head_s1;
		fill_v    = '0;
		fill_v[0] = head_s1[1];
		for (int k = 0; k < LN; k++) begin
			fill_v[1 + LW*k +: LW] = tab_s1[k].bits[st];
			st = tab_s1[k].exit_st[st];
		end
	end

	always_comb begin
		clean_c    = '0;
		clean_c[0] = fill_v[0] & fill_v[1];
		for (int i = 1; i < WW - 1; i++) begin
			clean_c[i] = fill_v[i] & (fill_v[i-1] | fill_v[i+1]);
		end
		clean_c[WW-1] = fill_v[WW-1] & clean_c[WW-2];
	end

	always_ff @(posedge clk) begin
		if (adv_s2) clean_s2 <= clean_c;
	end

	// ------------------------------------------------------------------
	// Stage 3: edge marks and per-lane search for the first falls. A
	// pulse still high at bins 61 and 62 with bin 63 low closes at 63,
	// so mark it as a fall there.
	// ------------------------------------------------------------------
	logic [WW-1:0]        rise_c, fall_c;
	bfpf_pkg::fall_lane_t fl_c  [LN];
	bfpf_pkg::fall_lane_t fl_s3 [LN];
	logic [WW-1:0]        rise_s3;
	logic                 ign_s3, init_s3, hi_s3;

	always_comb begin
		rise_c = '0;
		fall_c = '0;
		for (int i = 2; i < WW - 1; i++) begin
			rise_c[i] = ~clean_s2[i-2] & ~clean_s2[i-1] & clean_s2[i] & clean_s2[i+1];
			fall_c[i] = clean_s2[i-2] & clean_s2[i-1] & ~clean_s2[i] & ~clean_s2[i+1];
		end
		fall_c[WW-1] = clean_s2[WW-3] & clean_s2[WW-2] & ~clean_s2[WW-1];
	end

	for (genvar k = 0; k < LN; k++) begin : g_fall
		bfpf_fall_lane u_fall_lane (
			.ev  (fall_c[LW*k +: LW]),
			.res (fl_c[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			fl_s3   <= fl_c;
			rise_s3 <= rise_c;
			// a pulse high at bins 0 and 1 is ignored up to its fall
			ign_s3  <= clean_s2[0] & clean_s2[1];
			init_s3 <= ~clean_s2[0] & clean_s2[1] & clean_s2[2];
			hi_s3   <= clean_s2[WW-2] & clean_s2[WW-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: merge the lane falls into the first three of the window,
	// then skip the first one when the leading pulse is ignored. What is
	// left are the two closing bins that matter.
	// ------------------------------------------------------------------
	logic [1:0]    pre_c  [LN];
	logic [2:0]    slot_v_c;
	logic [PW-1:0] slot_p_c [bfpf_pkg::SLOT_N];
	logic          f1v_s4, f2v_s4, hend_s4, init_s4;
	logic [PW-1:0] f1_s4, f2_s4;
	logic [WW-1:0] rise_s4;

	always_comb begin
		logic [1:0] tot;
		logic [2:0] sum;
		tot = '0;
		for (int k = 0; k < LN; k++) begin
			pre_c[k] = tot;
			sum      = {1'b0, tot} + {1'b0, fl_s3[k].cnt};
			tot      = (sum > 3'(bfpf_pkg::SLOT_N)) ? 2'(bfpf_pkg::SLOT_N) : sum[1:0];
		end
	end

	always_comb begin
		logic [2:0] lo;
		logic [2:0] hi;
		logic [1:0] m;
		slot_v_c = '0;
		for (int j = 0; j < bfpf_pkg::SLOT_N; j++) begin
			slot_p_c[j] = '0;
			for (int k = 0; k < LN; k++) begin
				lo = {1'b0, pre_c[k]};
				hi = lo + {1'b0, fl_s3[k].cnt};
				m  = 2'(3'(j) - lo);
				if (lo <= 3'(j) && 3'(j) < hi) begin
					slot_v_c[j] = 1'b1;
					slot_p_c[j] = {bfpf_pkg::LIDX_W'(k), fl_s3[k].idx[m]};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			f1v_s4  <= ign_s3 ? slot_v_c[1] : slot_v_c[0];
			f1_s4   <= ign_s3 ? slot_p_c[1] : slot_p_c[0];
			f2v_s4  <= ign_s3 ? slot_v_c[2] : slot_v_c[1];
			f2_s4   <= ign_s3 ? slot_p_c[2] : slot_p_c[1];
			// the end rule is dropped while the leading pulse is still ignored
			hend_s4 <= hi_s3 & ~(ign_s3 & ~slot_v_c[0]);
			init_s4 <= init_s3;
			rise_s4 <= rise_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: window the rises. The first start is the last rise before
	// the first close; the second is the last rise after it, before the second close if any.
	// ------------------------------------------------------------------
	logic [WW-1:0]        win1_c, win2_c;
	bfpf_pkg::rise_lane_t r1_c  [LN];
	bfpf_pkg::rise_lane_t r2_c  [LN];
	bfpf_pkg::rise_lane_t r1_s5 [LN];
	bfpf_pkg::rise_lane_t r2_s5 [LN];
	logic                 f1v_s5, f2v_s5, hend_s5, init_s5;
	logic [PW-1:0]        f1_s5, f2_s5;

	always_comb begin
		for (int i = 0; i < WW; i++) begin
			win1_c[i] = rise_s4[i] & (~f1v_s4 | (PW'(i) < f1_s4));
			win2_c[i] = rise_s4[i] & f1v_s4 & (PW'(i) > f1_s4)
			            & (~f2v_s4 | (PW'(i) < f2_s4));
		end
	end

	for (genvar k = 0; k < LN; k++) begin : g_rise
		bfpf_rise_lane u_rise1_lane (
			.ev  (win1_c[LW*k +: LW]),
			.res (r1_c[k])
		);
		bfpf_rise_lane u_rise2_lane (
			.ev  (win2_c[LW*k +: LW]),
			.res (r2_c[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			r1_s5   <= r1_c;
			r2_s5   <= r2_c;
			f1v_s5  <= f1v_s4;
			f1_s5   <= f1_s4;
			f2v_s5  <= f2v_s4;
			f2_s5   <= f2_s4;
			hend_s5 <= hend_s4;
			init_s5 <= init_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: merge the lane rises, then widths, split and end rules.
	// A first pulse of 32 bins or more is cut at 31 and its rest becomes
	// the second pulse; a pulse high at bins 62 and 63 gets width 1, or
	// 31 when it started early enough.
	// ------------------------------------------------------------------
	logic [PW-1:0]                st1_c, st2_c;
	logic [PW:0]                  w1raw_c, w2raw_c, wsplit_c;
	logic [PW-1:0]                fs_c, ss_c;
	logic [bfpf_pkg::WID_W-1:0]   fw_c, sw_c;
	logic [PW-1:0]                fs_q, ss_q;
	logic [bfpf_pkg::WID_W-1:0]   fw_q, sw_q;

	always_comb begin
		st1_c = init_s5 ? bfpf_pkg::LATE_START_POS : '0;
		st2_c = '0;
		for (int k = 0; k < LN; k++) begin
			if (r1_s5[k].found) st1_c = {bfpf_pkg::LIDX_W'(k), r1_s5[k].idx};
			if (r2_s5[k].found) st2_c = {bfpf_pkg::LIDX_W'(k), r2_s5[k].idx};
		end
	end

	assign w1raw_c  = {1'b0, f1_s5} - {1'b0, st1_c};
	assign w2raw_c  = {1'b0, f2_s5} - {1'b0, st2_c};
	assign wsplit_c = w1raw_c - {1'b0, bfpf_pkg::SPLIT_OFS};

	always_comb begin
		fs_c = st1_c;
		fw_c = '0;
		ss_c = '0;
		sw_c = '0;
		if (f1v_s5) begin
			if (w1raw_c >= bfpf_pkg::SPLIT_MIN) begin
				fw_c = bfpf_pkg::WIDTH_CAP;
				ss_c = st1_c + bfpf_pkg::SPLIT_OFS;
				sw_c = (wsplit_c >= bfpf_pkg::SPLIT_MIN) ? bfpf_pkg::WIDTH_CAP
				                                         : bfpf_pkg::WID_W'(wsplit_c);
			end else begin
				fw_c = bfpf_pkg::WID_W'(w1raw_c);
				ss_c = st2_c;
				if (f2v_s5) begin
					sw_c = (w2raw_c >= bfpf_pkg::SPLIT_MIN) ? bfpf_pkg::WIDTH_CAP
					                                        : bfpf_pkg::WID_W'(w2raw_c);
				end else if (hend_s5) begin
					sw_c = ({1'b0, st2_c} <= bfpf_pkg::SPLIT_MIN) ? bfpf_pkg::WIDTH_CAP
					                                              : bfpf_pkg::END_WIDTH;
				end
			end
		end else if (hend_s5) begin
			if ({1'b0, st1_c} <= bfpf_pkg::SPLIT_MIN) begin
				fw_c = bfpf_pkg::WIDTH_CAP;
				ss_c = st1_c + bfpf_pkg::SPLIT_OFS;
				sw_c = bfpf_pkg::END_WIDTH;
			end else begin
				fw_c = bfpf_pkg::END_WIDTH;
			end
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk) begin
		if (adv_out) begin
			fs_q <= fs_c;
			fw_q <= fw_c;
			ss_q <= ss_c;
			sw_q <= sw_c;
		end
	end

	assign first_start  = fs_q;
	assign first_width  = fw_q;
	assign second_start = ss_q;
	assign second_width = sw_q;

endmodule

`default_nettype wire

@@ test/tb_binary_waveform_pulse_finder_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_waveform_pulse_finder_top
// Self-checking bench for the pulse finder. Each waveform item the block
// takes is run through a local model of the cleaning passes and the edge
// scan. Every result item is compared field by field with the oldest
// prediction; in all but the last phase both handshakes stall and idle at random.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [bfpf_pkg::POS_W-1:0] first_start;
	logic [bfpf_pkg::WID_W-1:0] first_width;
	logic [bfpf_pkg::POS_W-1:0] second_start;
	logic [bfpf_pkg::WID_W-1:0] second_width;
} pulse_pair_t;

typedef struct packed {
	logic [bfpf_pkg::WAVE_W-1:0] wave;
	pulse_pair_t                 pulses;
} pending_pulses_t;

class pulse_scoreboard;
	pending_pulses_t expected_q[$];
	int mismatches;
	int checked;
	int two_pulse_count;
	int empty_count;

	// Scan state of the waveform in hand
	int start_a, width_a, start_b, width_b;
	bit done_a, done_b;

	function new();
		mismatches      = 0;
		checked         = 0;
		two_pulse_count = 0;
		empty_count     = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function logic [bfpf_pkg::WID_W-1:0] limit_width(int w);
		if (w < 0)
			return '0;
		if (w > int'(bfpf_pkg::WIDTH_CAP))
			return bfpf_pkg::WIDTH_CAP;
		return w[bfpf_pkg::WID_W-1:0];
	endfunction

	// Close the pulse that is open at bin stop.
	function void close_pulse(int stop);
		if (!done_a && !done_b) begin
			width_a = stop - start_a;
			done_a  = 1'b1;
			if (width_a >= int'(bfpf_pkg::SPLIT_MIN)) begin
				start_b = start_a + int'(bfpf_pkg::SPLIT_OFS);
				width_b = width_a - int'(bfpf_pkg::SPLIT_OFS);
				done_b  = 1'b1;
				width_a = int'(bfpf_pkg::WIDTH_CAP);
			end
		end else if (done_a && !done_b) begin
			width_b = stop - start_b;
			done_b  = 1'b1;
			if (width_b >= int'(bfpf_pkg::SPLIT_MIN))
				width_b = int'(bfpf_pkg::WIDTH_CAP);
		end
	endfunction

	function pulse_pair_t find_pulses(logic [bfpf_pkg::WAVE_W-1:0] wave);
		logic [bfpf_pkg::WAVE_W-1:0] b;
		pulse_pair_t                 r;
		bit                          skip;
		b = wave;
		// in place, left to right: each step sees what the last one changed
		for (int i = 2; i < 63; i++) begin
			if (b[i-2] && b[i-1] && !b[i] && b[i+1])
				b[i] = 1'b1;
			if (b[i-2] && !b[i-1] && b[i] && b[i+1])
				b[i-1] = 1'b1;
		end
		if (b[0] && !b[1])
			b[0] = 1'b0;
		for (int i = 1; i < 63; i++) begin
			if (!b[i-1] && b[i] && !b[i+1])
				b[i] = 1'b0;
		end
		if (!b[62] && b[63])
			b[63] = 1'b0;

		start_a = 0;
		width_a = 0;
		start_b = 0;
		width_b = 0;
		done_a  = 1'b0;
		done_b  = 1'b0;
		skip    = 1'b0;
		if (wave != '0 && b != '0) begin
			if (b[0] && b[1])
				skip = 1'b1;
			else if (!b[0] && b[1] && b[2])
				start_a = int'(bfpf_pkg::LATE_START_POS);
			for (int i = 2; i < 63; i++) begin
				if (!b[i-2] && !b[i-1] && b[i] && b[i+1]) begin
					if (!done_a && !done_b)
						start_a = i;
					else if (done_a && !done_b)
						start_b = i;
				end else if (b[i-2] && b[i-1] && !b[i] && !b[i+1]) begin
					if (!skip)
						close_pulse(i);
					else
						skip = 1'b0;
				end
			end
			if (b[61] && b[62] && !b[63]) begin
				if (!skip)
					close_pulse(63);
			end else if (b[62] && b[63] && !skip) begin
				if (!done_a && !done_b) begin
					width_a = int'(bfpf_pkg::END_WIDTH);
					done_a  = 1'b1;
					if (64 - start_a >= int'(bfpf_pkg::SPLIT_MIN)) begin
						start_b = start_a + int'(bfpf_pkg::SPLIT_OFS);
						width_b = int'(bfpf_pkg::END_WIDTH);
						done_b  = 1'b1;
						width_a = int'(bfpf_pkg::WIDTH_CAP);
					end
				end else if (done_a && !done_b) begin
					width_b = int'(bfpf_pkg::END_WIDTH);
					done_b  = 1'b1;
					if (64 - start_b >= int'(bfpf_pkg::SPLIT_MIN))
						width_b = int'(bfpf_pkg::WIDTH_CAP);
				end
			end
		end
		r.first_start  = start_a[bfpf_pkg::POS_W-1:0];
		r.first_width  = limit_width(width_a);
		r.second_start = start_b[bfpf_pkg::POS_W-1:0];
		r.second_width = limit_width(width_b);
		return r;
	endfunction

	function void note_waveform(logic [bfpf_pkg::WAVE_W-1:0] wave);
		pending_pulses_t e;
		e.wave   = wave;
		e.pulses = find_pulses(wave);
		expected_q.insert(expected_q.size(), e);
	endfunction

	function void check_result(pulse_pair_t got);
		pending_pulses_t e;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing expected: fs=%0d fw=%0d ss=%0d sw=%0d",
					$realtime, got.first_start, got.first_width,
					got.second_start, got.second_width);
			return;
		end
		e = expected_q.pop_front();
		checked++;
		if (e.pulses.second_width != '0)
			two_pulse_count++;
		if (e.pulses == '0)
			empty_count++;
		if (got !== e.pulses) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: wave %h expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
					$realtime, e.wave,
					e.pulses.first_start, e.pulses.first_width,
					e.pulses.second_start, e.pulses.second_width,
					got.first_start, got.first_width,
					got.second_start, got.second_width);
		end
	endfunction
endclass

module tb_binary_waveform_pulse_finder_top;

	localparam int STALL_LIMIT  = 4000; // cycles with no item moving either way
	localparam int DRAIN_CYCLES = 24;   // well beyond the six-stage pipe
	localparam int PHASE_ITEMS  = 234;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          wave_valid   = 1'b0;
	logic [bfpf_pkg::WAVE_W-1:0]   waveform     = '0;
	logic                          result_ready = 1'b0;
	logic                          wave_ready;
	logic                          result_valid;
	logic [bfpf_pkg::POS_W-1:0]    first_start;
	logic [bfpf_pkg::WID_W-1:0]    first_width;
	logic [bfpf_pkg::POS_W-1:0]    second_start;
	logic [bfpf_pkg::WID_W-1:0]    second_width;

	pulse_scoreboard sb = new();

	int send_idle_pct = 24;
	int recv_idle_pct = 68;
	int quiet_cycles  = 0;
	int sent_items    = 0;

	binary_waveform_pulse_finder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wave_valid   (wave_valid),
		.wave_ready   (wave_ready),
		.waveform     (waveform),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.first_start  (first_start),
		.first_width  (first_width),
		.second_start (second_start),
		.second_width (second_width)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: drop ready at random, at the falling edge only.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sample both channels at the rising edge, before the block's own
	// updates land; feed the scoreboard and the stall watchdog.
	always @(posedge clk) begin
		pulse_pair_t got;
		if (arst_n) begin
			if (wave_valid && wave_ready)
				sb.note_waveform(waveform);
			if (result_valid && result_ready) begin
				got.first_start  = first_start;
				got.first_width  = first_width;
				got.second_start = second_start;
				got.second_width = second_width;
				sb.check_result(got);
			end
			if ((wave_valid && wave_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Offer one waveform item; enter and leave at a falling edge. Valid is
	// only lowered for an idle cycle, so it is never dropped and raised in
	// one step.
	task automatic send_wave(input logic [bfpf_pkg::WAVE_W-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			wave_valid <= 1'b0;
			@(negedge clk);
		end
		wave_valid <= 1'b1;
		waveform   <= w;
		@(posedge clk);
		while (!wave_ready)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	// Hold the sender until every predicted result has come back.
	task automatic hold_until_drained();
		wave_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Mostly pulse trains with random run lengths and gaps, some with noise
	// flipped in, some inverted, and some raw random words.
	function automatic logic [bfpf_pkg::WAVE_W-1:0] make_wave();
		logic [bfpf_pkg::WAVE_W-1:0] w;
		int pick, pos, len, runs, idx;
		pick = $urandom_range(99);
		if (pick < 15)
			return {$urandom, $urandom};
		w    = '0;
		pos  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
		runs = $urandom_range(1, 4);
		while (runs > 0 && pos < 64) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 12);
			for (int i = 0; i < len && pos + i < 64; i++)
				w[pos+i] = 1'b1;
			pos += len + $urandom_range(1, 6);
			runs--;
		end
		if (pick < 40) begin
			repeat ($urandom_range(1, 3)) begin
				idx    = $urandom_range(63);
				w[idx] = ~w[idx];
			end
		end
		if (pick >= 92)
			w = ~w;
		return w;
	endfunction

	logic [bfpf_pkg::WAVE_W-1:0] directed_waves [] = '{
		64'h0000_0000_0000_0000,  // empty
		64'hFFFF_FFFF_FFFF_FFFF,  // all high, ignored from bin 0
		64'h0000_0000_0000_0001,  // lone bin 0
		64'h8000_0000_0000_0000,  // lone bin 63
		64'h0000_0000_0000_0003,  // high at bins 0 and 1
		64'h0000_0000_0000_0006,  // start at bin 1
		64'h0000_0000_0000_000E,
		64'h0000_0000_0000_01B0,  // one-bin gap to fill
		64'h5555_5555_5555_5555,
		64'hAAAA_AAAA_AAAA_AAAA,
		64'h0000_0000_0001_0000,  // isolated one
		64'h0000_0000_0000_0F00,
		64'h0000_00F0_0000_0F00,  // two pulses
		64'h0F00_00F0_000F_0000,  // three pulses
		64'h0000_0000_0F00_000F,  // ignored pulse, then a real one
		64'h0007_FFFF_FFFF_FFF0,  // long pulse, split
		64'hFFFF_FFFF_0000_0000,  // high to the end of the window
		64'hFFFF_FFFF_FFFF_FFF0,  // long and high to the end
		64'hFFFF_FFFF_FFFF_FFFE,  // start at bin 1, high to the end
		64'h7000_0000_0000_0000,  // bins 60..62, 63 low
		64'h6000_0000_0000_0000,  // bins 61, 62, 63 low
		64'hC000_0000_0000_0000,  // bins 62, 63
		64'h0000_0000_0000_0DB6
	};

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_waves[k])
			send_wave(directed_waves[k]);
		hold_until_drained();

		// three idling profiles, draining between them
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (PHASE_ITEMS)
				send_wave(make_wave());
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d of %0d waveform items: %0d with a second pulse, %0d empty.",
			sb.checked, sent_items, sb.two_pulse_count, sb.empty_count);
		$display("Mismatches: %0d, results still outstanding: %0d.",
			sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
